// ===== hw/rtl/ssh_pkg.sv =====
// ----------------------------------------------------------------------------
// ssh_pkg
// Types and constants shared by the sampled string hash block.
// ----------------------------------------------------------------------------
package ssh_pkg;

  // Default width of the latched length and the unit counter.
  localparam int unsigned LengthBitsDefault = 32;

  // Hash arithmetic.
  localparam logic [31:0] HashMult   = 32'd257;
  localparam int unsigned FullLimit  = 96;  // strings up to this length hash every unit
  localparam int unsigned Window     = 32;  // units per sample window
  localparam int unsigned HalfWindow = 16;  // middle window starts this far before L/2

  // Input word: one code unit of a string.
  typedef struct packed {
    logic [15:0] code_unit;
    logic [31:0] string_length;
    logic        is_last;
  } ssh_in_t;

  // Output word: finished hash of one string.
  typedef struct packed {
    logic [31:0] hash_value;
    logic        length_error;
  } ssh_out_t;

endpackage

// ===== hw/rtl/ssh_window.sv =====
// ----------------------------------------------------------------------------
// ssh_window
// Decides whether a unit index falls in one of the sampled windows.
// ----------------------------------------------------------------------------
module ssh_window #(
  parameter int unsigned LengthBits = ssh_pkg::LengthBitsDefault
) (
  input  logic [LengthBits-1:0] idx_i,
  input  logic [LengthBits-1:0] len_i,
  output logic                  sel_o
);

  logic [LengthBits-1:0] mid;
  logic                  in_head;
  logic                  in_mid;
  logic                  in_tail;

  // len > 96 whenever these matter, so no term underflows or wraps.
  assign mid     = (len_i >> 1) - LengthBits'(ssh_pkg::HalfWindow);
  assign in_head = idx_i < LengthBits'(ssh_pkg::Window);
  assign in_mid  = (idx_i >= mid) && (idx_i < mid + LengthBits'(ssh_pkg::Window));
  assign in_tail = idx_i >= len_i - LengthBits'(ssh_pkg::Window);

  always_comb begin
    if (idx_i >= len_i) begin
      sel_o = 1'b0;
    end else if (len_i <= LengthBits'(ssh_pkg::FullLimit)) begin
      sel_o = 1'b1;
    end else begin
      sel_o = in_head || in_mid || in_tail;
    end
  end

endmodule

// ===== hw/rtl/sampled_string_hash_257.sv =====
// ----------------------------------------------------------------------------
// sampled_string_hash_257
// Multiplicative string hash (x257) over 16-bit code units, sampled windows
// for long strings.
// ----------------------------------------------------------------------------
// Output: out_valid_o rises in the cycle after the closing word is accepted.
// Throughput: one word per cycle unless a result waits on out_ready_i; the
//   x257 shift-add on the running hash is combinational, so words stream.
// Reset: rst_ni async, active low; clears the in-string flag and drops
//   out_valid_o. The hash, count, length and result payload registers are
//   not reset.
// ----------------------------------------------------------------------------
module sampled_string_hash_257 #(
  parameter int unsigned LengthBits = ssh_pkg::LengthBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ssh_pkg::ssh_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ssh_pkg::ssh_out_t out_data_o
);

  localparam logic [LengthBits-1:0] CountMax = '1;

  // String state
  logic                  in_string_q;
  logic [31:0]           hash_q;
  logic [LengthBits-1:0] index_q;
  logic [LengthBits-1:0] len_q;

  // Result register
  logic              out_valid_q;
  ssh_pkg::ssh_out_t out_q;

  // Working values for the current word
  logic                  accept;
  logic                  first;
  logic                  empty_word;
  logic [LengthBits-1:0] in_len;
  logic [LengthBits-1:0] cur_len;
  logic [LengthBits-1:0] cur_idx;
  logic [31:0]           cur_hash;
  logic                  sel;
  logic [31:0]           hash_d;
  logic [LengthBits-1:0] count_d;
  logic [31:0]           final_hash;

  // Output register frees up in the same cycle it is taken.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // First word of a string supplies the length and seeds the hash with it.
  assign in_len     = in_data_i.string_length[LengthBits-1:0];
  assign first      = !in_string_q;
  assign empty_word = first && (in_len == '0);
  assign cur_len    = first ? in_len : len_q;
  assign cur_idx    = first ? '0 : index_q;
  assign cur_hash   = first ? 32'(in_len) : hash_q;

  ssh_window #(
    .LengthBits(LengthBits)
  ) u_window (
    .idx_i(cur_idx),
    .len_i(cur_len),
    .sel_o(sel)
  );

  // Units outside the windows or past the length leave the hash alone.
  assign hash_d = sel ? (cur_hash * ssh_pkg::HashMult) + 32'(in_data_i.code_unit)
                      : cur_hash;

  // Unit count saturates instead of wrapping.
  assign count_d = (cur_idx == CountMax) ? cur_idx : cur_idx + LengthBits'(1);

  // Finish: fold in the hash shifted by length mod 32.
  assign final_hash = hash_d + (hash_d << cur_len[4:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_string_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // A new result wins over the old one leaving in the same cycle.
      if (accept && (empty_word || in_data_i.is_last)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // Empty-string marker: result 0 right away, stay idle.
      if (accept && !empty_word) begin
        in_string_q <= !in_data_i.is_last;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hash_q  <= hash_d;
      index_q <= count_d;
      len_q   <= cur_len;
      if (empty_word) begin
        out_q.hash_value   <= '0;
        out_q.length_error <= 1'b0;
      end else if (in_data_i.is_last) begin
        out_q.hash_value   <= final_hash;
        out_q.length_error <= count_d != cur_len;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
